@@ hw/rtl/rma_pkg.sv @@
package rma_pkg;

  // Default room count and the fixed field widths of the block.
  localparam int ROOMS_DEF = 16;
  localparam int TIME_W    = 32;
  localparam int FIN_W     = 48;
  localparam int BK_W      = 20;
  localparam int CFG_W     = 5;
  localparam int ROOM_W    = 4;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;

  localparam logic [CFG_W-1:0]   ROOMS_RST   = 5'd16;
  localparam logic [PADDR_W-1:0] ADDR_ROOMS  = 2'd0;
  localparam logic [FIN_W-1:0]   FINISH_MAX  = {FIN_W{1'b1}};
  localparam logic [BK_W-1:0]    COUNT_MAX   = {BK_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic init;   // a new item was taken: forget the previous search
    logic eval;   // the entry read last cycle is at the RAM output
    logic first;  // that entry is room zero
  } scan_ctl_t;

endpackage

@@ hw/rtl/rma_ram.sv @@
module rma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rma_scan.sv @@
module rma_scan #(
  parameter int IDX_W = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rma_pkg::scan_ctl_t       ctl_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [rma_pkg::TIME_W-1:0] start_i,
  input  logic                     entry_valid_i,
  input  logic [rma_pkg::FIN_W-1:0] fin_i,
  input  logic [rma_pkg::BK_W-1:0] bk_i,
  output logic                     found_o,
  output logic [IDX_W-1:0]         room_o,
  output logic [rma_pkg::BK_W-1:0] bk_o,
  output logic [rma_pkg::FIN_W-1:0] min_fin_o
);

  import rma_pkg::*;

  logic              found_q, found_d;
  logic [IDX_W-1:0]  free_room_q, free_room_d;
  logic [BK_W-1:0]   free_bk_q, free_bk_d;
  logic [FIN_W-1:0]  min_fin_q, min_fin_d;
  logic [IDX_W-1:0]  min_room_q, min_room_d;
  logic [BK_W-1:0]   min_bk_q, min_bk_d;
  logic [FIN_W-1:0]  fin;
  logic [BK_W-1:0]   bk;
  logic              is_free;
  logic              is_less;

  // Entries never written since the last clear read as zero.
  assign fin     = entry_valid_i ? fin_i : '0;
  assign bk      = entry_valid_i ? bk_i : '0;
  assign is_free = fin <= FIN_W'(start_i);
  assign is_less = ctl_i.first || (fin < min_fin_q);

  always_comb begin
    found_d     = found_q;
    free_room_d = free_room_q;
    free_bk_d   = free_bk_q;
    min_fin_d   = min_fin_q;
    min_room_d  = min_room_q;
    min_bk_d    = min_bk_q;
    if (ctl_i.init) begin
      found_d = 1'b0;
    end else if (ctl_i.eval) begin
      if (!found_q && is_free) begin
        found_d     = 1'b1;
        free_room_d = idx_i;
        free_bk_d   = bk;
      end
      if (is_less) begin
        min_fin_d  = fin;
        min_room_d = idx_i;
        min_bk_d   = bk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_room_q <= free_room_d;
    free_bk_q   <= free_bk_d;
    min_fin_q   <= min_fin_d;
    min_room_q  <= min_room_d;
    min_bk_q    <= min_bk_d;
  end

  assign found_o   = found_q;
  assign room_o    = found_q ? free_room_q : min_room_q;
  assign bk_o      = found_q ? free_bk_q : min_bk_q;
  assign min_fin_o = min_fin_q;

endmodule

@@ hw/rtl/rma_ctrl.sv @@
module rma_ctrl #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [CNT_W-1:0]   n_active_i,
  input  logic               out_free_i,
  output logic               ready_o,
  output logic               rd_en_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  output logic [IDX_W-1:0]   eval_idx_o,
  output rma_pkg::scan_ctl_t scan_o,
  output logic               commit_o
);

  import rma_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic              issue;

  assign issue = (state_q == ST_SCAN) && (rd_cnt_q < n_active_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rd_cnt_q == n_active_i) && pend_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Read counter and the registered index that follows the RAM read.
  always_comb begin
    rd_cnt_d   = rd_cnt_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    if (accept_i) begin
      rd_cnt_d = '0;
    end else if (issue) begin
      rd_cnt_d   = rd_cnt_q + CNT_W'(1);
      pend_d     = 1'b1;
      pend_idx_d = rd_cnt_q[IDX_W-1:0];
    end
  end

  // Outputs.
  always_comb begin
    ready_o     = (state_q == ST_IDLE);
    rd_en_o     = issue;
    rd_addr_o   = rd_cnt_q[IDX_W-1:0];
    eval_idx_o  = pend_idx_q;
    scan_o.init = accept_i;
    scan_o.eval = (state_q == ST_SCAN) && pend_q;
    scan_o.first = (pend_idx_q == '0);
    commit_o    = (state_q == ST_UPDATE) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
  end

endmodule

@@ hw/rtl/room_allocator_with_delay_top.sv @@
// Room allocator with delayed meetings. Each input item is a meeting request
// (start, end) and each gives exactly one result item: the room granted and
// the lowest-indexed most-booked room so far; tlast on the result echoes
// tlast on the request, and after a request marked last all room state
// returns to its reset value. The first room whose finish time is at or
// before the start takes the request and finishes at end; if none is free,
// the earliest-finishing room (lowest index on a tie) takes it and its
// finish time grows by the meeting length, saturating at 2^48 - 1. The
// result becomes valid after a scan over the n active rooms, in which the
// single read port of the room memory feeds one entry per cycle into a
// shared compare unit, and an update state that writes the chosen room
// back. The block is ready again as the result is registered, so a new
// item is taken only after the previous one has been written back. The
// update state waits while an earlier result sits unread in the output
// register and is not being taken that cycle.
// Input ready is high only while the block is idle, but a finished result
// waits in its own output register, so the next item is taken while the
// previous result is still unread.
// The room memory needs no clearing pass: per-room valid bits, cleared at
// reset and after each last item, make unwritten rooms read as empty.
module room_allocator_with_delay_top #(
  parameter int ROOMS = rma_pkg::ROOMS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // start_time, end_time
  input  logic                         s_axis_tlast,  // last
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // assigned_room, most_booked_room
  output logic                         m_axis_tlast,  // batch_end
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rma_pkg::PADDR_W-1:0]  paddr,
  input  logic [rma_pkg::PDATA_W-1:0]  pwdata,
  output logic [rma_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import rma_pkg::*;

  localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CNT_W = $clog2(ROOMS + 1);
  localparam int EXT_W = (IDX_W > ROOM_W) ? IDX_W : ROOM_W;
  localparam int ENT_W = FIN_W + BK_W;

  // Configuration register.
  logic [CFG_W-1:0] rooms_q;
  logic             cfg_wr;
  logic [CNT_W-1:0] n_active;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ROOMS);
  assign prdata = (paddr == ADDR_ROOMS) ? PDATA_W'(rooms_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_q <= ROOMS_RST;
    end else if (cfg_wr) begin
      rooms_q <= pwdata[CFG_W-1:0];
    end
  end

  // A count of zero acts as one room; counts above the room store clamp.
  always_comb begin
    if (rooms_q == '0) begin
      n_active = CNT_W'(1);
    end else if (int'(rooms_q) >= ROOMS) begin
      n_active = CNT_W'(ROOMS);
    end else begin
      n_active = CNT_W'(rooms_q);
    end
  end

  // Request capture.
  logic              in_accept;
  logic [TIME_W-1:0] start_q;
  logic [TIME_W-1:0] end_q;
  logic              last_q;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      start_q <= s_axis_tdata[TIME_W-1:0];
      end_q   <= s_axis_tdata[2*TIME_W-1:TIME_W];
      last_q  <= s_axis_tlast;
    end
  end

  // Sequencer.
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] eval_idx;
  scan_ctl_t        scan_ctl;
  logic             commit;

  assign out_free = !out_valid_q || m_axis_tready;

  rma_ctrl #(
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .n_active_i (n_active),
    .out_free_i (out_free),
    .ready_o    (s_axis_tready),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .eval_idx_o (eval_idx),
    .scan_o     (scan_ctl),
    .commit_o   (commit)
  );

  // Room store: finish time in the low bits, booking count above it.
  logic [ENT_W-1:0] rd_data;
  logic [ENT_W-1:0] wr_data;
  logic [IDX_W-1:0] room;
  logic [ROOMS-1:0] valid_q, valid_d;

  rma_ram #(
    .WIDTH(ENT_W),
    .DEPTH(ROOMS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (room),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Shared compare unit walking the active rooms.
  logic             found;
  logic [BK_W-1:0]  room_bk;
  logic [FIN_W-1:0] min_fin;

  rma_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (scan_ctl),
    .idx_i         (eval_idx),
    .start_i       (start_q),
    .entry_valid_i (valid_q[eval_idx]),
    .fin_i         (rd_data[FIN_W-1:0]),
    .bk_i          (rd_data[ENT_W-1:FIN_W]),
    .found_o       (found),
    .room_o        (room),
    .bk_o          (room_bk),
    .min_fin_o     (min_fin)
  );

  // Update of the chosen room. A delayed meeting adds its length to the
  // earliest finish time, saturating; a free room simply takes the end time.
  logic [TIME_W-1:0] mtg_len;
  logic [FIN_W:0]    fin_sum;
  logic [FIN_W-1:0]  new_fin;
  logic [BK_W-1:0]   new_bk;
  logic [BK_W-1:0]   best_count_q, best_count_d;
  logic [IDX_W-1:0]  best_room_q, best_room_d;
  logic              better;
  logic [IDX_W-1:0]  best_next;

  assign mtg_len = (end_q > start_q) ? (end_q - start_q) : '0;
  assign fin_sum = {1'b0, min_fin} + (FIN_W + 1)'(mtg_len);
  assign new_fin = found ? FIN_W'(end_q) :
                   (fin_sum[FIN_W] ? FINISH_MAX : fin_sum[FIN_W-1:0]);
  assign new_bk  = (room_bk == COUNT_MAX) ? room_bk : room_bk + BK_W'(1);
  assign wr_data = {new_bk, new_fin};

  assign better = (new_bk > best_count_q) ||
                  ((new_bk == best_count_q) && (room < best_room_q));
  assign best_next = better ? room : best_room_q;

  always_comb begin
    valid_d      = valid_q;
    best_count_d = best_count_q;
    best_room_d  = best_room_q;
    if (commit) begin
      if (last_q) begin
        valid_d      = '0;
        best_count_d = '0;
        best_room_d  = '0;
      end else begin
        valid_d[room] = 1'b1;
        if (better) begin
          best_count_d = new_bk;
          best_room_d  = room;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      best_count_q <= '0;
      best_room_q  <= '0;
    end else begin
      valid_q      <= valid_d;
      best_count_q <= best_count_d;
      best_room_q  <= best_room_d;
    end
  end

  // Result register; room indices are reported in four bits.
  logic [EXT_W-1:0]  room_ext;
  logic [EXT_W-1:0]  best_ext;
  logic [ROOM_W-1:0] out_room_q;
  logic [ROOM_W-1:0] out_best_q;
  logic              out_last_q;

  assign room_ext = EXT_W'(room);
  assign best_ext = EXT_W'(best_next);

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_room_q <= room_ext[ROOM_W-1:0];
      out_best_q <= best_ext[ROOM_W-1:0];
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_best_q, out_room_q};
  assign m_axis_tlast  = out_last_q;

endmodule
